>>> sv/ptts_pkg.sv
// Shared types and constants for the periodic task tick scheduler.
package ptts_pkg;

    localparam int TASKS      = 8;
    localparam int ID_W       = 4;
    localparam int FIRED_ID_W = 3;
    localparam int TIME_W     = 16;
    localparam int POS_W      = $clog2(TASKS + 1);
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [2:0] {
        KIND_TICK    = 3'd0,
        KIND_CREATE  = 3'd1,
        KIND_SUSPEND = 3'd2,
        KIND_RESUME  = 3'd3,
        KIND_DELETE  = 3'd4
    } kind_t;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic              adv;
        logic              step;
        logic [TIME_W-1:0] tick_step;
        logic              cmd_en;
        kind_t             kind;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] period;
    } cell_ctl_t;

    // Status returned by each cell.
    typedef struct packed {
        logic present;
        logic hit;
        logic hit_last;
    } cell_stat_t;

endpackage

>>> sv/ptts_cell.sv
// One task slot: countdown, period and flags, with a token stage of the walk chain.
module ptts_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ptts_pkg::cell_ctl_t  ctl,
    input  logic                 sel,
    input  logic                 tok_in,
    input  logic                 later_in,
    output logic                 tok_out,
    output logic                 later_out,
    output ptts_pkg::cell_stat_t stat
);
    import ptts_pkg::*;

    logic [TIME_W-1:0] cd_reg, cd_next;
    logic [TIME_W-1:0] per_reg, per_next;
    logic              present_reg, present_next;
    logic              ready_reg, ready_next;
    logic              tok_reg, tok_next;
    logic              fire;

    assign fire      = present_reg & ready_reg & (cd_reg == '0);
    assign later_out = fire | later_in;
    assign tok_out   = tok_reg;

    assign stat.present  = present_reg;
    assign stat.hit      = tok_reg & fire;
    assign stat.hit_last = tok_reg & fire & ~later_in;

    always_comb
    begin
        cd_next      = cd_reg;
        per_next     = per_reg;
        present_next = present_reg;
        ready_next   = ready_reg;
        tok_next     = ctl.adv ? tok_in : tok_reg;
        if (ctl.step && tok_reg && present_reg && ready_reg)
        begin
            // A task that fires reloads from its period; the rest count down.
            if (fire)
                cd_next = per_reg - ctl.tick_step;
            else
                cd_next = cd_reg - ctl.tick_step;
        end
        if (ctl.cmd_en && sel)
        begin
            case (ctl.kind)
                KIND_CREATE:
                begin
                    cd_next      = ctl.delay;
                    per_next     = ctl.period;
                    present_next = 1'b1;
                    ready_next   = 1'b1;
                end
                KIND_SUSPEND:
                begin
                    if (present_reg)
                        ready_next = 1'b0;
                end
                KIND_RESUME:
                begin
                    if (present_reg)
                        ready_next = 1'b1;
                end
                KIND_DELETE:
                begin
                    if (present_reg)
                    begin
                        cd_next      = '0;
                        per_next     = '0;
                        present_next = 1'b0;
                    end
                end
                default:
                begin
                    cd_next = cd_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cd_reg      <= '0;
            per_reg     <= '0;
            present_reg <= 1'b0;
            ready_reg   <= 1'b0;
            tok_reg     <= 1'b0;
        end
        else
        begin
            cd_reg      <= cd_next;
            per_reg     <= per_next;
            present_reg <= present_next;
            ready_reg   <= ready_next;
            tok_reg     <= tok_next;
        end
    end

endmodule

>>> sv/periodic_task_tick_scheduler_top.sv
// Top level of the periodic task tick scheduler: sequencer, output register and cell row.
//
// Usage:
// - The input stream carries one command word: s_tuser holds the kind (tick, create,
//   suspend, resume, delete) and s_tdata the task id, delay and period.
// - The cfg channel writes tick_step; it is always ready and must only be used
//   while the block is idle.
// - A tick passes a token down the row of task cells, one cell per cycle unless a
//   firing cell waits for the output register. The walk and its closing cycle keep
//   the block busy. Each present and ready task with a zero countdown produces one
//   word on the output as the token reaches it; m_tlast marks the final one. A tick
//   with no firing gives a single word with fired clear in its last cycle.
// - A command is captured, then applied and answered with one status word.
// - s_tready is high only while no word is being worked on; a new word is taken
//   while the previous result still sits in the output register.
// - When m_tready is low the token holds at a firing cell until the output register
//   can take its word, so no result is lost.
// - Reset clears all task slots, sets tick_step to 1 and empties the output.
module periodic_task_tick_scheduler_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // task_id [3:0], delay [19:4], period [35:20], zero [39:36]
    input  logic [ptts_pkg::IN_DATA_W-1:0]     s_tdata,
    // kind [2:0]
    input  logic [2:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // fired_id [2:0], status [3], zero [7:4]
    output logic [ptts_pkg::OUT_DATA_W-1:0]    m_tdata,
    // fired [0]
    output logic                               m_tuser,
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ptts_pkg::TIME_W-1:0]        cfg_data
);
    import ptts_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_TICK = 3'b010,
        ST_CMD  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              any_fired_reg, any_fired_next;
    logic [TIME_W-1:0] tick_step_reg, tick_step_next;
    kind_t             cmd_kind_reg, cmd_kind_next;
    logic [ID_W-1:0]   cmd_id_reg, cmd_id_next;
    logic [TIME_W-1:0] cmd_delay_reg, cmd_delay_next;
    logic [TIME_W-1:0] cmd_period_reg, cmd_period_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_fired_reg, out_fired_next;
    logic [FIRED_ID_W-1:0] out_id_reg, out_id_next;
    logic                  out_status_reg, out_status_next;
    logic                  out_last_reg, out_last_next;

    logic             accept, can_emit, walk, step, start, end_phase, end_emit;
    logic             cmd_en, out_load, hit_any, last_any, id_ok, id_present, cmd_status;
    logic [7:0]       pos_wide;
    cell_ctl_t        ctl;
    cell_stat_t       stat_vec [TASKS];
    logic [TASKS-1:0] sel_vec, present_vec, hit_vec, hit_last_vec, tok_vec;
    logic [TASKS:0]   tok_chain, later_chain;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_fired_reg;
    assign m_tlast   = out_last_reg;
    assign m_tdata   = {{(OUT_DATA_W - FIRED_ID_W - 1){1'b0}}, out_status_reg, out_id_reg};

    assign can_emit  = ~out_valid_reg | m_tready;
    assign hit_any   = |hit_vec;
    assign last_any  = |hit_last_vec;
    assign walk      = (state_reg == ST_TICK) && (pos_reg != POS_W'(TASKS));
    assign step      = walk & (~hit_any | can_emit);
    assign start     = accept && (kind_t'(s_tuser) == KIND_TICK);
    assign end_phase = (state_reg == ST_TICK) && (pos_reg == POS_W'(TASKS));
    assign end_emit  = end_phase & ~any_fired_reg;
    assign cmd_en    = (state_reg == ST_CMD) & can_emit;
    assign out_load  = (walk & hit_any & can_emit) | (end_emit & can_emit) | cmd_en;
    assign pos_wide  = 8'(pos_reg);

    assign id_ok      = |sel_vec;
    assign id_present = |(sel_vec & present_vec);

    always_comb
    begin
        case (cmd_kind_reg)
            KIND_CREATE:  cmd_status = ~id_ok;
            KIND_SUSPEND: cmd_status = ~id_present;
            KIND_RESUME:  cmd_status = ~id_present;
            KIND_DELETE:  cmd_status = ~id_present;
            default:      cmd_status = 1'b1;
        endcase
    end

    assign ctl.adv       = start | step;
    assign ctl.step      = step;
    assign ctl.tick_step = tick_step_reg;
    assign ctl.cmd_en    = cmd_en;
    assign ctl.kind      = cmd_kind_reg;
    assign ctl.delay     = cmd_delay_reg;
    assign ctl.period    = cmd_period_reg;

    assign tok_chain[0]       = start;
    assign later_chain[TASKS] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < TASKS; gi++)
        begin : g_cell
            assign sel_vec[gi]      = (cmd_id_reg == ID_W'(gi));
            assign present_vec[gi]  = stat_vec[gi].present;
            assign hit_vec[gi]      = stat_vec[gi].hit;
            assign hit_last_vec[gi] = stat_vec[gi].hit_last;
            assign tok_vec[gi]      = tok_chain[gi+1];

            ptts_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .sel       (sel_vec[gi]),
                .tok_in    (tok_chain[gi]),
                .later_in  (later_chain[gi+1]),
                .tok_out   (tok_chain[gi+1]),
                .later_out (later_chain[gi]),
                .stat      (stat_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        any_fired_next  = any_fired_reg;
        tick_step_next  = (cfg_valid & cfg_ready) ? cfg_data : tick_step_reg;
        cmd_kind_next   = cmd_kind_reg;
        cmd_id_next     = cmd_id_reg;
        cmd_delay_next  = cmd_delay_reg;
        cmd_period_next = cmd_period_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_kind_next   = kind_t'(s_tuser);
                    cmd_id_next     = s_tdata[3:0];
                    cmd_delay_next  = s_tdata[19:4];
                    cmd_period_next = s_tdata[35:20];
                    pos_next        = '0;
                    any_fired_next  = 1'b0;
                    state_next      = start ? ST_TICK : ST_CMD;
                end
            end
            ST_TICK:
            begin
                if (step)
                begin
                    pos_next       = POS_W'(pos_reg + 1'b1);
                    any_fired_next = any_fired_reg | hit_any;
                end
                if (end_phase && (any_fired_reg || can_emit))
                    state_next = ST_IDLE;
            end
            ST_CMD:
            begin
                if (cmd_en)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_load ? 1'b1 : (out_valid_reg & ~m_tready);
        out_fired_next  = out_fired_reg;
        out_id_next     = out_id_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        if (out_load)
        begin
            if (walk)
            begin
                out_fired_next  = 1'b1;
                out_id_next     = pos_wide[FIRED_ID_W-1:0];
                out_status_next = 1'b0;
                out_last_next   = last_any;
            end
            else
            begin
                out_fired_next  = 1'b0;
                out_id_next     = '0;
                out_status_next = cmd_en ? cmd_status : 1'b0;
                out_last_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            any_fired_reg <= 1'b0;
            tick_step_reg <= TIME_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            any_fired_reg <= any_fired_next;
            tick_step_reg <= tick_step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_kind_reg   <= cmd_kind_next;
        cmd_id_reg     <= cmd_id_next;
        cmd_delay_reg  <= cmd_delay_next;
        cmd_period_reg <= cmd_period_next;
        out_fired_reg  <= out_fired_next;
        out_id_reg     <= out_id_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    // At most one cell holds the walk token.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one cell holds the token");

    // The token lives only while a tick is being walked.
    a_token_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_TICK) |-> (tok_vec == '0))
        else $error("token present outside a tick");

    // Past the last cell the token is gone.
    a_token_end: assert property (@(posedge clk) disable iff (!rst_n)
        end_phase |-> (tok_vec == '0))
        else $error("token still in the row after the walk");

    // A word that does not report a firing always closes its run.
    a_nofire_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !out_fired_next) |=> out_last_reg)
        else $error("non-firing word without last");

endmodule
